### rtl/btql_pkg.sv
// shared constants and codes for the bitmap text quad layout block
package btql_pkg;

	localparam int GLYPH_COUNT_DEF = 256;
	localparam int KERN_PAIRS_DEF  = 256;
	localparam int FRAC_BITS_DEF   = 8;

	// texture coordinate and divider operand widths
	localparam int TEX_W = 16;
	localparam int DIM_W = 13;

	// item opcodes
	localparam logic [1:0] OP_GLYPH  = 2'd0;
	localparam logic [1:0] OP_KERN   = 2'd1;
	localparam logic [1:0] OP_PLACE  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_SCALE    = 3'd0;
	localparam logic [2:0] CFG_ATLAS_W  = 3'd1;
	localparam logic [2:0] CFG_ATLAS_H  = 3'd2;
	localparam logic [2:0] CFG_LINE_H   = 3'd3;
	localparam logic [2:0] CFG_COLOR    = 3'd4;
	localparam logic [2:0] CFG_ORIGIN_X = 3'd5;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd6;

endpackage

### rtl/bitmap_text_quad_layout_top.sv
// top level of the bitmap text quad layout engine
//
// input channel: one transaction per item (opcode, codes, glyph data, kerning,
// last_char), taken when in_valid is high and in_stall low. a glyph load or a
// kerning pair load is stored in the accepting cycle and in_stall stays low.
// a place item raises in_stall until its work is finished: the glyph store
// read, four scaled terms on the shared multiplier, the texture coordinates
// on the shared divider, the linear kerning search (skipped on a last char),
// the pen update, then four output transactions, each of which out_stall
// can hold. an unknown glyph finishes after the store read and emits nothing.
// output channel: one transaction per vertex, four per known glyph, quad_end
// on the fourth; a high out_stall simply holds the vertex on the port.
// configuration: cfg_ready is always high; writes belong between items.
// reset: registers return to their defaults, all glyphs become unknown, the
// kerning table is empty and no string is open. no clearing pass is needed.
module bitmap_text_quad_layout_top #(
	parameter int GLYPH_COUNT = btql_pkg::GLYPH_COUNT_DEF,
	parameter int KERN_PAIRS  = btql_pkg::KERN_PAIRS_DEF,
	parameter int FRAC_BITS   = btql_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [7:0]         char_code,
	input  logic [7:0]         next_code,
	input  logic [11:0]        atlas_x,
	input  logic [11:0]        atlas_y,
	input  logic [11:0]        glyph_width,
	input  logic [11:0]        glyph_height,
	input  logic signed [11:0] offset_x,
	input  logic signed [11:0] offset_y,
	input  logic signed [11:0] advance,
	input  logic signed [11:0] kern_amount,
	input  logic               last_char,
	// vertex channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] vertex_x,
	output logic signed [23:0] vertex_y,
	output logic [15:0]        tex_u,
	output logic [15:0]        tex_v,
	output logic [31:0]        color,
	output logic               quad_end
);

	localparam int GI_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int KA_W  = (KERN_PAIRS > 1) ? $clog2(KERN_PAIRS) : 1;
	localparam int KC_W  = $clog2(KERN_PAIRS + 1);
	// wide enough for origin y shifted by the fraction plus two products
	localparam int ACC_W = 30 + FRAC_BITS;
	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-23){1'b0}}, {23{1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-23){1'b1}}, {23{1'b0}}};

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_READ = 10'b0000000010,
		ST_MUL  = 10'b0000000100,
		ST_ACC  = 10'b0000001000,
		ST_DIVS = 10'b0000010000,
		ST_DIVW = 10'b0000100000,
		ST_KERN = 10'b0001000000,
		ST_PMUL = 10'b0010000000,
		ST_PADD = 10'b0100000000,
		ST_EMIT = 10'b1000000000
	} state_t;

	function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
		if (v > SAT_HI)
			return 24'sh7FFFFF;
		else if (v < SAT_LO)
			return 24'sh800000;
		else
			return v[23:0];
	endfunction

	state_t state_q;

	// configuration registers
	logic [15:0]        scale_q;
	logic [12:0]        atlas_w_q;
	logic [12:0]        atlas_h_q;
	logic [11:0]        line_h_q;
	logic [31:0]        color_q;
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;

	// stores
	logic [47:0]           rect_mem [GLYPH_COUNT];
	logic [35:0]           met_mem  [GLYPH_COUNT];
	logic [27:0]           kern_mem [KERN_PAIRS];
	logic [GLYPH_COUNT-1:0] gvalid_q;
	logic [KC_W-1:0]       kcount_q;
	logic [47:0]           rect_rd_q;
	logic [35:0]           met_rd_q;
	logic [27:0]           kern_rd_q;

	// item context
	logic [7:0]  code_q;
	logic [7:0]  next_q;
	logic        last_q;
	logic        known_q;
	logic signed [23:0] pen_q;
	logic        active_q;

	// working terms
	logic [1:0]               mi_q;
	logic [1:0]               di_q;
	logic [1:0]               vi_q;
	logic signed [29:0]       prod_q;
	logic signed [ACC_W-1:0]  x1_q, y1_q, x2_q, y2_q;
	logic [15:0]              u1_q, u2_q, v1_q, v2_q;
	logic signed [11:0]       kern_q;
	logic [KC_W-1:0]          ka_q;
	logic                     kv_q;

	logic                     accept;
	logic [GI_W-1:0]          gidx;
	logic                     g_in_range;
	logic signed [12:0]       mul_a;
	logic signed [16:0]       mul_s;
	logic signed [29:0]       mul_p;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  pen_ext;
	logic signed [ACC_W-1:0]  y0;
	logic signed [ACC_W-1:0]  origin_ext;
	logic                     div_start;
	logic                     div_done;
	logic [15:0]              div_quo;
	logic [12:0]              div_num;
	logic [12:0]              div_den;
	logic                     kern_hit;

	assign accept     = in_valid && !in_stall;
	assign gidx       = char_code[GI_W-1:0];
	assign g_in_range = {1'b0, char_code} < 9'(GLYPH_COUNT);
	assign cfg_ready  = 1'b1;
	assign in_stall   = state_q != ST_IDLE;

	// shared multiplier operand selection
	always_comb begin
		case (mi_q)
			2'd0:    mul_a = {met_rd_q[35], met_rd_q[35:24]};
			2'd1:    mul_a = {met_rd_q[23], met_rd_q[23:12]};
			2'd2:    mul_a = {1'b0, rect_rd_q[23:12]};
			default: mul_a = {1'b0, rect_rd_q[11:0]};
		endcase
		if (state_q == ST_PMUL)
			mul_a = 13'({kern_q[11], kern_q}) + 13'({met_rd_q[11], met_rd_q[11:0]});
	end
	assign mul_s    = {1'b0, scale_q};
	assign mul_p    = mul_a * mul_s;
	assign prod_ext = {{(ACC_W-30){prod_q[29]}}, prod_q};
	assign pen_ext  = {{(ACC_W-24){pen_q[23]}}, pen_q};
	assign y0 = ({{(ACC_W-16){origin_y_q[15]}}, origin_y_q}
		+ {{(ACC_W-12){1'b0}}, line_h_q}) <<< FRAC_BITS;
	assign origin_ext = {{(ACC_W-16){origin_x_q[15]}}, origin_x_q} <<< FRAC_BITS;

	// divider operands: u1, u2, v1, v2 in turn
	always_comb begin
		case (di_q)
			2'd0:    div_num = {1'b0, rect_rd_q[47:36]};
			2'd1:    div_num = 13'(rect_rd_q[47:36]) + 13'(rect_rd_q[23:12]);
			2'd2:    div_num = {1'b0, rect_rd_q[35:24]};
			default: div_num = 13'(rect_rd_q[35:24]) + 13'(rect_rd_q[11:0]);
		endcase
		div_den = di_q[1] ? atlas_h_q : atlas_w_q;
	end
	assign div_start = state_q == ST_DIVS;

	btql_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign kern_hit = kv_q && kern_rd_q[27:20] == code_q && kern_rd_q[19:12] == next_q;

	// glyph and kerning memories
	always_ff @(posedge clk) begin
		if (accept && opcode == btql_pkg::OP_GLYPH && g_in_range) begin
			rect_mem[gidx] <= {atlas_x, atlas_y, glyph_width, glyph_height};
			met_mem[gidx]  <= {offset_x, offset_y, advance};
		end
		if (accept && opcode == btql_pkg::OP_PLACE) begin
			rect_rd_q <= rect_mem[gidx];
			met_rd_q  <= met_mem[gidx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == btql_pkg::OP_KERN && kcount_q != KC_W'(KERN_PAIRS))
			kern_mem[kcount_q[KA_W-1:0]] <= {char_code, next_code, kern_amount};
		kern_rd_q <= kern_mem[ka_q[KA_W-1:0]];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= 16'd768;
			atlas_w_q  <= 13'd256;
			atlas_h_q  <= 13'd256;
			line_h_q   <= '0;
			color_q    <= '1;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				btql_pkg::CFG_SCALE:    scale_q    <= cfg_data[15:0];
				btql_pkg::CFG_ATLAS_W:  atlas_w_q  <= cfg_data[12:0];
				btql_pkg::CFG_ATLAS_H:  atlas_h_q  <= cfg_data[12:0];
				btql_pkg::CFG_LINE_H:   line_h_q   <= cfg_data[11:0];
				btql_pkg::CFG_COLOR:    color_q    <= cfg_data;
				btql_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data[15:0];
				btql_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			gvalid_q <= '0;
			kcount_q <= '0;
			pen_q    <= '0;
			active_q <= 1'b0;
			mi_q     <= '0;
			di_q     <= '0;
			vi_q     <= '0;
			ka_q     <= '0;
			kv_q     <= 1'b0;
			known_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							btql_pkg::OP_GLYPH: begin
								if (g_in_range)
									gvalid_q[gidx] <= 1'b1;
							end
							btql_pkg::OP_KERN: begin
								if (kcount_q != KC_W'(KERN_PAIRS))
									kcount_q <= kcount_q + KC_W'(1);
							end
							btql_pkg::OP_PLACE: begin
								// first character of a string loads the pen
								if (!active_q) begin
									pen_q    <= sat24(origin_ext);
									active_q <= 1'b1;
								end
								known_q <= g_in_range && gvalid_q[gidx];
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					mi_q <= '0;
					if (known_q) begin
						state_q <= ST_MUL;
					end else begin
						if (last_q) begin
							pen_q    <= '0;
							active_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					mi_q <= mi_q + 2'd1;
					if (mi_q == 2'd3) begin
						di_q    <= '0;
						state_q <= ST_DIVS;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						di_q <= di_q + 2'd1;
						if (di_q != 2'd3) begin
							state_q <= ST_DIVS;
						end else if (last_q) begin
							state_q <= ST_PMUL;
						end else begin
							ka_q    <= '0;
							kv_q    <= 1'b0;
							state_q <= ST_KERN;
						end
					end
				end
				ST_KERN: begin
					// reads issue one a cycle, each compared in the cycle after
					if (kern_hit) begin
						state_q <= ST_PMUL;
					end else if (ka_q < kcount_q) begin
						kv_q <= 1'b1;
						ka_q <= ka_q + KC_W'(1);
					end else if (kv_q) begin
						kv_q <= 1'b0;
					end else begin
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: state_q <= ST_PADD;
				ST_PADD: begin
					if (last_q) begin
						pen_q    <= '0;
						active_q <= 1'b0;
					end else begin
						pen_q <= sat24(pen_ext + prod_ext);
					end
					vi_q    <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						vi_q <= vi_q + 2'd1;
						if (vi_q == 2'd3)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && opcode == btql_pkg::OP_PLACE) begin
			code_q <= char_code;
			next_q <= next_code;
			last_q <= last_char;
		end
		if (state_q == ST_MUL || state_q == ST_PMUL)
			prod_q <= mul_p;
		if (state_q == ST_ACC) begin
			case (mi_q)
				2'd0:    x1_q <= pen_ext + prod_ext;
				2'd1:    y1_q <= y0 - prod_ext;
				2'd2:    x2_q <= x1_q + prod_ext;
				default: y2_q <= y1_q - prod_ext;
			endcase
		end
		if (state_q == ST_DIVW && div_done) begin
			case (di_q)
				2'd0:    u1_q <= div_quo;
				2'd1:    u2_q <= div_quo;
				2'd2:    v1_q <= div_quo;
				default: v2_q <= div_quo;
			endcase
		end
		if (state_q == ST_DIVW && div_done && di_q == 2'd3)
			kern_q <= '0;
		else if (state_q == ST_KERN && kern_hit)
			kern_q <= kern_rd_q[11:0];
	end

	// vertex order: (x1,y2), (x1,y1), (x2,y2), (x2,y1)
	assign out_valid = state_q == ST_EMIT;
	assign vertex_x  = vi_q[1] ? sat24(x2_q) : sat24(x1_q);
	assign vertex_y  = vi_q[0] ? sat24(y1_q) : sat24(y2_q);
	assign tex_u     = vi_q[1] ? u2_q : u1_q;
	assign tex_v     = vi_q[0] ? v1_q : v2_q;
	assign color     = color_q;
	assign quad_end  = vi_q == 2'd3;

endmodule

### rtl/btql_div.sv
// iterative restoring divider giving floor(num * 65536 / den), saturated
module btql_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [btql_pkg::DIM_W-1:0]      num,
	input  logic [btql_pkg::DIM_W-1:0]      den,
	output logic                            done,
	output logic [btql_pkg::TEX_W-1:0]      quo
);

	logic [btql_pkg::DIM_W-1:0] rem_q;
	logic [btql_pkg::DIM_W-1:0] den_q;
	logic [btql_pkg::TEX_W-1:0] quo_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       sat_q;
	logic                       done_q;
	logic [btql_pkg::DIM_W:0]   rem2;
	logic                       fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
			sat_q <= num >= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= btql_pkg::DIM_W'(rem2 - {1'b0, den_q});
				quo_q <= {quo_q[btql_pkg::TEX_W-2:0], 1'b1};
			end else begin
				rem_q <= rem2[btql_pkg::DIM_W-1:0];
				quo_q <= {quo_q[btql_pkg::TEX_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = sat_q ? '1 : quo_q;

endmodule

### bench/bitmap_text_quad_layout_top_tb.sv
// self-checking testbench for the bitmap text quad layout engine
module bitmap_text_quad_layout_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one input transaction of the item channel
	typedef struct {
		logic [1:0]         opcode;
		logic [7:0]         char_code;
		logic [7:0]         next_code;
		logic [11:0]        atlas_x;
		logic [11:0]        atlas_y;
		logic [11:0]        glyph_width;
		logic [11:0]        glyph_height;
		logic signed [11:0] offset_x;
		logic signed [11:0] offset_y;
		logic signed [11:0] advance;
		logic signed [11:0] kern_amount;
		logic               last_char;
	} item_t;

	// one vertex of a glyph quad
	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [15:0]        u;
		logic [15:0]        v;
		logic [31:0]        rgba;
		logic               qend;
	} vertex_t;

	// layout predictor and store of vertices still owed by the block
	class vertex_board;
		int errors = 0;
		vertex_t vertex_q[$];
		// glyph store
		longint g_ax[256], g_ay[256], g_w[256], g_h[256];
		longint g_ox[256], g_oy[256], g_adv[256];
		bit     g_known[256];
		// kerning pairs
		int     k_first[256], k_second[256];
		longint k_amount[256];
		int     k_count = 0;
		// pen and registers
		longint pen = 0;
		bit     in_string = 0;
		longint scale = 768, atlas_w = 256, atlas_h = 256, line_h = 0;
		logic [31:0] rgba = 32'hFFFF_FFFF;
		longint org_x = 0, org_y = 0;

		function new();
			foreach (g_known[i]) g_known[i] = 0;
		endfunction

		function longint sat24(longint v);
			if (v > 8388607)
				return 8388607;
			if (v < -8388608)
				return -8388608;
			return v;
		endfunction

		function longint tex_coord(longint n, longint d);
			longint q;
			if (d == 0)
				return 65535;
			q = (n << 16) / d;
			return (q > 65535) ? 65535 : q;
		endfunction

		function longint kern_of(int a, int b);
			for (int i = 0; i < k_count; i++)
				if (k_first[i] == a && k_second[i] == b)
					return k_amount[i];
			return 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				btql_pkg::CFG_SCALE:    scale = data[15:0];
				btql_pkg::CFG_ATLAS_W:  atlas_w = data[12:0];
				btql_pkg::CFG_ATLAS_H:  atlas_h = data[12:0];
				btql_pkg::CFG_LINE_H:   line_h = data[11:0];
				btql_pkg::CFG_COLOR:    rgba = data;
				btql_pkg::CFG_ORIGIN_X: org_x = longint'($signed(data[15:0]));
				btql_pkg::CFG_ORIGIN_Y: org_y = longint'($signed(data[15:0]));
				default: ;
			endcase
		endfunction

		function void add_vertex(longint x, longint y, longint u, longint v, bit e);
			vertex_t vx;
			vx.x = 24'(sat24(x));
			vx.y = 24'(sat24(y));
			vx.u = 16'(u);
			vx.v = 16'(v);
			vx.rgba = rgba;
			vx.qend = e;
			vertex_q = {vertex_q, vx};
		endfunction

		// accepted item: update the model state and queue its vertices
		function void note_item(item_t it);
			int c;
			longint y0, x1, y1, x2, y2, u1, u2, v1, v2, kern;
			c = it.char_code;
			case (it.opcode)
				btql_pkg::OP_GLYPH: begin
					g_ax[c] = it.atlas_x;
					g_ay[c] = it.atlas_y;
					g_w[c] = it.glyph_width;
					g_h[c] = it.glyph_height;
					g_ox[c] = it.offset_x;
					g_oy[c] = it.offset_y;
					g_adv[c] = it.advance;
					g_known[c] = 1;
				end
				btql_pkg::OP_KERN: begin
					if (k_count < 256) begin
						k_first[k_count] = c;
						k_second[k_count] = it.next_code;
						k_amount[k_count] = it.kern_amount;
						k_count++;
					end
				end
				btql_pkg::OP_PLACE: begin
					if (!in_string) begin
						pen = sat24(org_x * 256);
						in_string = 1;
					end
					if (g_known[c]) begin
						y0 = (org_y + line_h) * 256;
						x1 = pen + g_ox[c] * scale;
						y1 = y0 - g_oy[c] * scale;
						x2 = x1 + g_w[c] * scale;
						y2 = y1 - g_h[c] * scale;
						u1 = tex_coord(g_ax[c], atlas_w);
						u2 = tex_coord(g_ax[c] + g_w[c], atlas_w);
						v1 = tex_coord(g_ay[c], atlas_h);
						v2 = tex_coord(g_ay[c] + g_h[c], atlas_h);
						kern = it.last_char ? 0 : kern_of(c, it.next_code);
						add_vertex(x1, y2, u1, v2, 0);
						add_vertex(x1, y1, u1, v1, 0);
						add_vertex(x2, y2, u2, v2, 0);
						add_vertex(x2, y1, u2, v1, 1);
						pen = sat24(pen + (kern + g_adv[c]) * scale);
					end
					if (it.last_char) begin
						pen = 0;
						in_string = 0;
					end
				end
				default: ;
			endcase
		endfunction

		function void field_check(string name, longint e, longint a);
			if (e != a) begin
				$display("%0t ns: %s expected %0d actual %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t w;
			if (vertex_q.size() == 0) begin
				$display("%0t ns: vertex with none expected, x %0d y %0d", $time,
					got.x, got.y);
				errors++;
				return;
			end
			w = vertex_q.pop_front();
			field_check("vertex_x", w.x, got.x);
			field_check("vertex_y", w.y, got.y);
			field_check("tex_u", w.u, got.u);
			field_check("tex_v", w.v, got.v);
			field_check("color", w.rgba, got.rgba);
			field_check("quad_end", w.qend, got.qend);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall;
	item_t cur;
	logic out_valid, out_stall;
	logic signed [23:0] vertex_x, vertex_y;
	logic [15:0] tex_u, tex_v;
	logic [31:0] color;
	logic quad_end;

	vertex_board sb = new();
	bit hold_req = 0;     // asks the receiver for one long hold-off
	int idle_cycles = 0;
	int glyph_pool[8];    // codes used by the strings of the current phase

	bitmap_text_quad_layout_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(cur.opcode), .char_code(cur.char_code), .next_code(cur.next_code),
		.atlas_x(cur.atlas_x), .atlas_y(cur.atlas_y),
		.glyph_width(cur.glyph_width), .glyph_height(cur.glyph_height),
		.offset_x(cur.offset_x), .offset_y(cur.offset_y),
		.advance(cur.advance), .kern_amount(cur.kern_amount),
		.last_char(cur.last_char),
		.out_valid(out_valid), .out_stall(out_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y),
		.tex_u(tex_u), .tex_v(tex_v), .color(color), .quad_end(quad_end)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap lengths: mostly none or short, now and then long
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// vertex transactions are checked at the rising edge
	always @(posedge clk) begin
		vertex_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.x = vertex_x;
			got.y = vertex_y;
			got.u = tex_u;
			got.v = tex_v;
			got.rgba = color;
			got.qend = quad_end;
			sb.check_vertex(got);
		end
	end

	// watchdog: too long without any transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == 4000) begin
			$display("bitmap_text_quad_layout_top: mismatch");
			$finish;
		end
	end

	// receiver: random stalls, quiet stretches, and one long hold-off on request
	initial begin
		int r, quiet;
		quiet = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold-off so the block backs up into the item channel
				out_stall <= 1'b1;
				repeat (800) @(negedge clk);
				hold_req = 0;
				out_stall <= 1'b0;
			end else if (quiet > 0) begin
				quiet--;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					quiet = $urandom_range(50, 200);
					out_stall <= 1'b0;
				end else if (r < 30) begin
					out_stall <= 1'b1;
					repeat ((r < 27) ? $urandom_range(0, 2) : $urandom_range(9, 39))
						@(negedge clk);
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// offer one item, wait for its transaction, then leave the given gap
	task automatic send_item(item_t it, int gap);
		@(negedge clk);
		cur <= it;
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		sb.note_item(it);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// random payload, so unused fields toggle too
	function item_t noise_item();
		item_t it;
		it.opcode = 2'($urandom);
		it.char_code = 8'($urandom);
		it.next_code = 8'($urandom);
		it.atlas_x = 12'($urandom);
		it.atlas_y = 12'($urandom);
		it.glyph_width = 12'($urandom);
		it.glyph_height = 12'($urandom);
		it.offset_x = 12'($urandom);
		it.offset_y = 12'($urandom);
		it.advance = 12'($urandom);
		it.kern_amount = 12'($urandom);
		it.last_char = 1'($urandom);
		return it;
	endfunction

	function item_t glyph_item(int code, int ax, int ay, int w, int h,
		int ox, int oy, int adv);
		item_t it;
		it = noise_item();
		it.opcode = btql_pkg::OP_GLYPH;
		it.char_code = 8'(code);
		it.atlas_x = 12'(ax);
		it.atlas_y = 12'(ay);
		it.glyph_width = 12'(w);
		it.glyph_height = 12'(h);
		it.offset_x = 12'(ox);
		it.offset_y = 12'(oy);
		it.advance = 12'(adv);
		return it;
	endfunction

	function item_t kern_item(int a, int b, int amount);
		item_t it;
		it = noise_item();
		it.opcode = btql_pkg::OP_KERN;
		it.char_code = 8'(a);
		it.next_code = 8'(b);
		it.kern_amount = 12'(amount);
		return it;
	endfunction

	function item_t place_item(int code, int nxt, bit last);
		item_t it;
		it = noise_item();
		it.opcode = btql_pkg::OP_PLACE;
		it.char_code = 8'(code);
		it.next_code = 8'(nxt);
		it.last_char = last;
		return it;
	endfunction

	// glyph with mostly modest metrics, sometimes full-range ones
	function item_t rand_glyph(int code);
		item_t it;
		it = noise_item();
		it.opcode = btql_pkg::OP_GLYPH;
		it.char_code = 8'(code);
		if ($urandom_range(0, 9) < 7) begin
			it.atlas_x = 12'($urandom_range(0, 255));
			it.atlas_y = 12'($urandom_range(0, 255));
			it.glyph_width = 12'($urandom_range(0, 32));
			it.glyph_height = 12'($urandom_range(0, 32));
			it.offset_x = 12'($signed($urandom_range(0, 16)) - 8);
			it.offset_y = 12'($signed($urandom_range(0, 16)) - 8);
			it.advance = 12'($urandom_range(0, 16));
		end
		return it;
	endfunction

	function int pool_code();
		if ($urandom_range(0, 99) < 85)
			return glyph_pool[$urandom_range(0, 7)];
		return $urandom_range(0, 255);
	endfunction

	// drain the block, then pause for any unknown glyph still in flight
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.vertex_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(int s, int aw, int ah, int lh, logic [31:0] rgba,
		int ox, int oy);
		wait_idle();
		write_reg(btql_pkg::CFG_SCALE, s);
		write_reg(btql_pkg::CFG_ATLAS_W, aw);
		write_reg(btql_pkg::CFG_ATLAS_H, ah);
		write_reg(btql_pkg::CFG_LINE_H, lh);
		write_reg(btql_pkg::CFG_COLOR, rgba);
		write_reg(btql_pkg::CFG_ORIGIN_X, ox);
		write_reg(btql_pkg::CFG_ORIGIN_Y, oy);
	endtask

	// one phase of random traffic: glyph loads, pairs, then strings of places
	task automatic random_phase(int n_items, int n_pairs);
		int done, len, codes[6];
		item_t it;
		for (int i = 0; i < 8; i++)
			glyph_pool[i] = $urandom_range(0, 255);
		glyph_pool[0] = ($urandom_range(0, 1) != 0) ? 0 : 255;
		for (int i = 0; i < 6; i++)
			send_item(rand_glyph(glyph_pool[i]), pick_gap());
		for (int i = 0; i < n_pairs; i++)
			send_item(kern_item(pool_code(), pool_code(), $urandom), pick_gap());
		done = 6 + n_pairs;
		while (done < n_items) begin
			len = $urandom_range(1, 6);
			foreach (codes[i])
				codes[i] = pool_code();
			for (int i = 0; i < len; i++) begin
				// occasional reload, new pair or stray opcode inside a string
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 2))
						0: it = rand_glyph(pool_code());
						1: it = kern_item(pool_code(), pool_code(), $urandom);
						default: begin
							it = noise_item();
							it.opcode = btql_pkg::OP_UNUSED;
						end
					endcase
					send_item(it, pick_gap());
					done++;
				end
				send_item(place_item(codes[i], (i + 1 < len) ? codes[i + 1] : $urandom,
					i == len - 1), pick_gap());
				done++;
			end
		end
	endtask

	initial begin
		item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = btql_pkg::CFG_SCALE;
		cfg_data = '0;
		cur = noise_item();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at reset settings: extremes, duplicates, specials
		send_item(glyph_item(65, 10, 20, 8, 12, 1, 11, 9), 0);
		send_item(glyph_item(0, 4095, 4095, 4095, 4095, -2048, 2047, 2047), 1);
		send_item(glyph_item(255, 0, 0, 0, 0, 2047, -2048, -2048), 0);
		send_item(kern_item(65, 0, -2048), 0);
		send_item(kern_item(65, 0, 2047), 2);       // duplicate pair, first wins
		send_item(kern_item(0, 255, 5), 0);
		send_item(kern_item(255, 65, 100), 0);      // must be ignored on a last char
		it = noise_item();
		it.opcode = btql_pkg::OP_UNUSED;            // unused opcode
		send_item(it, 0);
		send_item(place_item(65, 0, 0), 0);
		send_item(place_item(0, 255, 0), 3);
		send_item(place_item(66, 65, 0), 0);        // unknown glyph mid-string
		send_item(glyph_item(65, 100, 4, 30, 2, -3, 0, 12), 0); // reload mid-string
		send_item(place_item(65, 66, 0), 0);
		send_item(place_item(255, 65, 1), 0);
		send_item(place_item(66, 65, 1), 0);        // unknown glyph closes a string
		send_item(place_item(65, 0, 1), 20);        // one-character string
		send_item(place_item(0, 65, 0), 0);
		send_item(place_item(65, 0, 1), 0);

		random_phase(30, 4);

		// largest scale and atlas, extreme origins; receiver holds off for a while
		configure(65535, 4096, 4096, 4095, 32'h0, 32767, -32768);
		hold_req = 1;
		random_phase(40, 5);

		// zero scale, unit atlas
		configure(0, 1, 1, 0, 32'hA5A5_5A5A, -32768, 32767);
		random_phase(30, 3);

		// zero divisors saturate the texture coordinates
		configure(256, 0, 0, $urandom_range(0, 4095), $urandom,
			$urandom_range(0, 65535), $urandom_range(0, 65535));
		random_phase(30, 3);

		// fill the kerning table past its end, then more strings
		configure($urandom_range(0, 65535), $urandom_range(1, 4096),
			$urandom_range(1, 4096), $urandom_range(0, 4095), $urandom,
			$urandom_range(0, 65535), $urandom_range(0, 65535));
		for (int i = 0; i < 260; i++)
			send_item(kern_item($urandom_range(0, 255), $urandom_range(0, 255), $urandom),
				($urandom_range(0, 3) == 0) ? 1 : 0);
		random_phase(40, 2);

		configure(768, 256, 256, 0, 32'hFFFF_FFFF, 0, 0);
		random_phase(30, 2);

		wait_idle();
		if (sb.errors == 0)
			$display("bitmap_text_quad_layout_top: match");
		else
			$display("bitmap_text_quad_layout_top: mismatch");
		$finish;
	end
endmodule

### bitmap_text_quad_layout_top.f
rtl/btql_pkg.sv
rtl/btql_div.sv
rtl/bitmap_text_quad_layout_top.sv
bench/bitmap_text_quad_layout_top_tb.sv
